// ===== src/vpibs_pkg.sv =====
// Shared types, constants and helper functions for the valve pull-in boost sequencer.
package vpibs_pkg;

	localparam int VALVE_COUNT = 9;
	localparam int GROUP_SIZE  = 3;
	localparam int NUM_GROUPS  = (VALVE_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;

	localparam int TARGET_W = 16;
	localparam int NOW_W    = 32;
	localparam int PIT_W    = 16;
	localparam int DRIVE_W  = 9;
	localparam int BOOST_W  = 3;

	localparam logic [PIT_W-1:0] PIT_RESET = 16'd200;

	// targets with any bit at or above VALVE_COUNT are rejected
	localparam logic [TARGET_W-1:0] VALID_TARGETS = TARGET_W'((64'd1 << VALVE_COUNT) - 64'd1);

	typedef logic [VALVE_COUNT-1:0] valve_mask_t;
	typedef logic [NUM_GROUPS-1:0]  group_mask_t;

	typedef enum logic [1:0] {
		KIND_SET    = 2'd0,
		KIND_TICK   = 2'd1,
		KIND_CANCEL = 2'd2,
		KIND_FAIL   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FAULT   = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]          kind;
		logic [TARGET_W-1:0] target;
		logic [NOW_W-1:0]    now_ms;
	} item_t;

	typedef struct packed {
		valve_mask_t valve_on;
		valve_mask_t pulling;
		group_mask_t boost;
		logic        fault;
	} state_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] valve_drive;
		logic [BOOST_W-1:0] boost_drive;
		logic [DRIVE_W-1:0] pulling_mask;
		status_t            status;
		logic               last;
	} result_t;

	function automatic group_mask_t groups_needed(valve_mask_t pulling);
		group_mask_t g;
		g = '0;
		for (int gi = 0; gi < NUM_GROUPS; gi++) begin
			for (int b = 0; b < GROUP_SIZE; b++) begin
				if (gi * GROUP_SIZE + b < VALVE_COUNT) begin
					if (pulling[gi * GROUP_SIZE + b]) begin
						g[gi] = 1'b1;
					end
				end
			end
		end
		return g;
	endfunction

	function automatic logic [DRIVE_W-1:0] fit_drive(valve_mask_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[DRIVE_W-1:0];
	endfunction

	function automatic logic [BOOST_W-1:0] fit_boost(group_mask_t b);
		logic [63:0] w;
		w = 64'(b);
		return w[BOOST_W-1:0];
	endfunction

	function automatic result_t make_result(valve_mask_t v, group_mask_t b, valve_mask_t p,
			status_t s, logic last);
		result_t r;
		r.valve_drive  = fit_drive(v);
		r.boost_drive  = fit_boost(b);
		r.pulling_mask = fit_drive(p);
		r.status       = s;
		r.last         = last;
		return r;
	endfunction

endpackage

// ===== src/vpibs_item_if.sv =====
// Input item channel: command kind, target mask and timestamp.
interface vpibs_item_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        kind;
	logic [vpibs_pkg::TARGET_W-1:0]    target;
	logic [vpibs_pkg::NOW_W-1:0]       now_ms;

	modport source (output valid, output kind, output target, output now_ms, input ready);
	modport sink   (input valid, input kind, input target, input now_ms, output ready);
endinterface

// ===== src/vpibs_result_if.sv =====
// Result channel: drive outputs after one phase.
interface vpibs_result_if;
	logic                          valid;
	logic                          ready;
	logic [vpibs_pkg::DRIVE_W-1:0] valve_drive;
	logic [vpibs_pkg::BOOST_W-1:0] boost_drive;
	logic [vpibs_pkg::DRIVE_W-1:0] pulling_mask;
	logic [1:0]                    status;
	logic                          last;

	modport source (output valid, output valve_drive, output boost_drive,
		output pulling_mask, output status, output last, input ready);
	modport sink   (input valid, input valve_drive, input boost_drive,
		input pulling_mask, input status, input last, output ready);
endinterface

// ===== src/vpibs_cfg_if.sv =====
// Configuration write channel for the pull-in time register.
interface vpibs_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [vpibs_pkg::PIT_W-1:0] pull_in_time_ms;

	modport source (output valid, output pull_in_time_ms, input ready);
	modport sink   (input valid, input pull_in_time_ms, output ready);
endinterface

// ===== src/valve_pull_in_boost_sequencer_core.sv =====
// A word accepted on the item port is registered in the s1 stage; its result
// words enter res_s2 after the single result port drains the previous word's.
// Set and cancel give three result words, one per cycle while result.ready is
// high; tick, driver_failure, rejected and faulted words give one word each.
// Reset clears valve, pull-in, boost and fault state and loads a 200 ms pull-in
// time; opening timestamps are not reset and are written when a valve opens.
module valve_pull_in_boost_sequencer_core (
	input  logic                   clk,
	input  logic                   arst_n,
	vpibs_item_if.sink             item,
	vpibs_result_if.source         result,
	vpibs_cfg_if.sink              cfg
);

	logic                        valid_s1;
	vpibs_pkg::item_t            item_s1;

	vpibs_pkg::state_t           st_q;
	vpibs_pkg::state_t           nxt;
	logic [vpibs_pkg::PIT_W-1:0] pit_q;

	vpibs_pkg::result_t [2:0]    res;
	vpibs_pkg::result_t [2:0]    res_s2;
	logic [1:0]                  nlast;
	logic [1:0]                  nlast_s2;
	logic                        res_valid_s2;
	logic [1:0]                  phase_q;
	vpibs_pkg::result_t          res_out;

	vpibs_pkg::valve_mask_t      open_we;
	vpibs_pkg::valve_mask_t      expired;

	logic out_pop;
	logic out_done;
	logic proc_fire;

	assign out_pop   = res_valid_s2 && result.ready;
	assign out_done  = out_pop && (phase_q == nlast_s2);
	assign proc_fire = valid_s1 && (!res_valid_s2 || out_done);

	assign item.ready = !valid_s1 || proc_fire;
	assign cfg.ready  = 1'b1;

	vpibs_step u_step (
		.item    (item_s1),
		.cur     (st_q),
		.expired (expired),
		.nxt     (nxt),
		.res     (res),
		.nlast   (nlast),
		.open_we (open_we)
	);

	vpibs_timer u_timer (
		.clk          (clk),
		.open_we      (open_we & {vpibs_pkg::VALVE_COUNT{proc_fire}}),
		.now_ms       (item_s1.now_ms),
		.pull_in_time (pit_q),
		.expired      (expired)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			st_q         <= '0;
			pit_q        <= vpibs_pkg::PIT_RESET;
			res_valid_s2 <= 1'b0;
			phase_q      <= 2'd0;
			nlast_s2     <= 2'd0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (cfg.valid) begin
				pit_q <= cfg.pull_in_time_ms;
			end
			if (proc_fire) begin
				st_q         <= nxt;
				res_valid_s2 <= 1'b1;
				phase_q      <= 2'd0;
				nlast_s2     <= nlast;
			end else if (out_done) begin
				res_valid_s2 <= 1'b0;
			end else if (out_pop) begin
				phase_q <= phase_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.kind   <= item.kind;
			item_s1.target <= item.target;
			item_s1.now_ms <= item.now_ms;
		end
		if (proc_fire) begin
			res_s2 <= res;
		end
	end

	always_comb begin
		case (phase_q)
			2'd0:    res_out = res_s2[0];
			2'd1:    res_out = res_s2[1];
			2'd2:    res_out = res_s2[2];
			default: res_out = res_s2[0];
		endcase
	end

	assign result.valid        = res_valid_s2;
	assign result.valve_drive  = res_out.valve_drive;
	assign result.boost_drive  = res_out.boost_drive;
	assign result.pulling_mask = res_out.pulling_mask;
	assign result.status       = res_out.status;
	assign result.last         = res_out.last;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> (phase_q <= nlast_s2))
		else $error("result phase beyond final word");

	a_last_on_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> (result.last == (phase_q == nlast_s2)))
		else $error("last flag does not match final phase");

	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fault |=> st_q.fault)
		else $error("fault latch cleared without reset");

	a_boost_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.boost == vpibs_pkg::groups_needed(st_q.pulling))
		else $error("boost state out of step with pulling valves");

endmodule

// ===== src/vpibs_timer.sv =====
// Per-valve opening timestamps and pull-in expiry compare.
module vpibs_timer (
	input  logic                          clk,
	input  vpibs_pkg::valve_mask_t        open_we,
	input  logic [vpibs_pkg::NOW_W-1:0]   now_ms,
	input  logic [vpibs_pkg::PIT_W-1:0]   pull_in_time,
	output vpibs_pkg::valve_mask_t        expired
);

	logic [vpibs_pkg::NOW_W-1:0] open_q [vpibs_pkg::VALVE_COUNT];

	always_ff @(posedge clk) begin
		for (int i = 0; i < vpibs_pkg::VALVE_COUNT; i++) begin
			if (open_we[i]) begin
				open_q[i] <= now_ms;
			end
		end
	end

	// wrap-safe: modular difference against zero-extended limit
	always_comb begin
		for (int i = 0; i < vpibs_pkg::VALVE_COUNT; i++) begin
			expired[i] = (now_ms - open_q[i]) >= vpibs_pkg::NOW_W'(pull_in_time);
		end
	end

endmodule

// ===== src/vpibs_step.sv =====
// Next-state and three-phase result computation for one input word.
module vpibs_step (
	input  vpibs_pkg::item_t              item,
	input  vpibs_pkg::state_t             cur,
	input  vpibs_pkg::valve_mask_t        expired,
	output vpibs_pkg::state_t             nxt,
	output vpibs_pkg::result_t [2:0]      res,
	output logic [1:0]                    nlast,
	output vpibs_pkg::valve_mask_t        open_we
);

	vpibs_pkg::kind_t       kind;
	vpibs_pkg::valve_mask_t tgt;
	vpibs_pkg::valve_mask_t retained;
	vpibs_pkg::valve_mask_t opened;
	vpibs_pkg::valve_mask_t pull_kept;
	vpibs_pkg::valve_mask_t pull_new;
	vpibs_pkg::valve_mask_t tick_pull;
	vpibs_pkg::group_mask_t boost_new;
	vpibs_pkg::group_mask_t tick_boost;
	logic                   bad_target;

	assign kind       = vpibs_pkg::kind_t'(item.kind);
	assign bad_target = (item.target & ~vpibs_pkg::VALID_TARGETS) != '0;

	// cancel keeps only valves that finished pulling in
	assign tgt = (kind == vpibs_pkg::KIND_CANCEL) ? (cur.valve_on & ~cur.pulling)
		: vpibs_pkg::valve_mask_t'(item.target);

	assign retained  = cur.valve_on & tgt;
	assign opened    = tgt & ~cur.valve_on;
	assign pull_kept = cur.pulling & tgt;
	assign pull_new  = pull_kept | opened;
	assign boost_new = vpibs_pkg::groups_needed(pull_new);

	assign tick_pull  = cur.pulling & ~expired;
	assign tick_boost = vpibs_pkg::groups_needed(tick_pull);

	always_comb begin
		nxt     = cur;
		open_we = '0;
		nlast   = 2'd0;
		res[0]  = vpibs_pkg::make_result(cur.valve_on, cur.boost, cur.pulling,
			vpibs_pkg::ST_OK, 1'b1);
		res[1]  = res[0];
		res[2]  = res[0];
		if (kind == vpibs_pkg::KIND_FAIL) begin
			nxt.valve_on = '0;
			nxt.pulling  = '0;
			nxt.boost    = '0;
			nxt.fault    = 1'b1;
			res[0] = vpibs_pkg::make_result('0, '0, '0, vpibs_pkg::ST_FAULT, 1'b1);
		end else if (cur.fault) begin
			res[0].status = vpibs_pkg::ST_FAULT;
		end else begin
			case (kind)
				vpibs_pkg::KIND_TICK: begin
					nxt.pulling = tick_pull;
					nxt.boost   = tick_boost;
					res[0] = vpibs_pkg::make_result(cur.valve_on, tick_boost, tick_pull,
						vpibs_pkg::ST_OK, 1'b1);
				end
				vpibs_pkg::KIND_SET, vpibs_pkg::KIND_CANCEL: begin
					if (kind == vpibs_pkg::KIND_SET && bad_target) begin
						res[0].status = vpibs_pkg::ST_INVALID;
					end else begin
						// break-before-make: release, boost, then energize
						nxt.valve_on = tgt;
						nxt.pulling  = pull_new;
						nxt.boost    = boost_new;
						open_we      = opened;
						nlast        = 2'd2;
						res[0] = vpibs_pkg::make_result(retained, cur.boost, pull_kept,
							vpibs_pkg::ST_OK, 1'b0);
						res[1] = vpibs_pkg::make_result(retained, boost_new, pull_new,
							vpibs_pkg::ST_OK, 1'b0);
						res[2] = vpibs_pkg::make_result(tgt, boost_new, pull_new,
							vpibs_pkg::ST_OK, 1'b1);
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the valve pull-in boost sequencer core.
`timescale 1ns / 100ps

module tb;
	import vpibs_pkg::*;

	localparam int RX_HOLD    = 400;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE     = 6;

	logic clk = 1'b0;
	logic arst_n;

	vpibs_item_if   item_ch();
	vpibs_result_if res_ch();
	vpibs_cfg_if    cfg_ch();

	valve_pull_in_boost_sequencer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predicted block state
	valve_mask_t      coils_on;
	valve_mask_t      pulling;
	group_mask_t      boost_en;
	logic [NOW_W-1:0] opened_at [VALVE_COUNT];
	logic             fault;
	logic [PIT_W-1:0] pull_in_ms;

	result_t drive_q[$];
	result_t want;
	int      err_cnt = 0;
	int      idle_cycles = 0;
	bit      no_idle = 1'b0;
	logic    hold_tog = 1'b0;
	logic    hold_seen = 1'b0;
	int      rx_hold_left = 0;
	int      rx_stall_left = 0;
	logic [NOW_W-1:0] clock_ms;

	function automatic int pick_gap();
		int r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic group_mask_t boost_for(valve_mask_t p);
		group_mask_t g;
		g = '0;
		for (int i = 0; i < VALVE_COUNT; i++) begin
			if (p[i]) begin
				g[i / GROUP_SIZE] = 1'b1;
			end
		end
		return g;
	endfunction

	function automatic void push_drive(status_t s, logic fin);
		result_t r;
		r.valve_drive  = coils_on;
		r.boost_drive  = boost_en;
		r.pulling_mask = pulling;
		r.status       = s;
		r.last         = fin;
		drive_q.push_back(r);
	endfunction

	// break-before-make: release, boost, energize
	function automatic void apply_mask(valve_mask_t tgt, logic [NOW_W-1:0] now);
		valve_mask_t opening;
		opening = tgt & ~coils_on;
		coils_on = coils_on & tgt;
		pulling = pulling & tgt;
		push_drive(ST_OK, 1'b0);
		for (int i = 0; i < VALVE_COUNT; i++) begin
			if (opening[i]) begin
				opened_at[i] = now;
				pulling[i] = 1'b1;
			end
		end
		boost_en = boost_for(pulling);
		push_drive(ST_OK, 1'b0);
		coils_on = tgt;
		push_drive(ST_OK, 1'b1);
	endfunction

	function automatic void predict_drive(kind_t k, logic [TARGET_W-1:0] tgt,
			logic [NOW_W-1:0] now);
		logic [NOW_W-1:0] elapsed;
		if (k == KIND_FAIL) begin
			coils_on = '0;
			pulling = '0;
			boost_en = '0;
			fault = 1'b1;
			push_drive(ST_FAULT, 1'b1);
			return;
		end
		if (fault) begin
			push_drive(ST_FAULT, 1'b1);
			return;
		end
		case (k)
			KIND_SET: begin
				if ((tgt & ~VALID_TARGETS) != '0) begin
					push_drive(ST_INVALID, 1'b1);
				end else begin
					apply_mask(tgt[VALVE_COUNT-1:0], now);
				end
			end
			KIND_CANCEL: begin
				apply_mask(coils_on & ~pulling, now);
			end
			default: begin
				for (int i = 0; i < VALVE_COUNT; i++) begin
					elapsed = now - opened_at[i];
					if (pulling[i] && elapsed >= NOW_W'(pull_in_ms)) begin
						pulling[i] = 1'b0;
					end
				end
				boost_en = boost_for(pulling);
				push_drive(ST_OK, 1'b1);
			end
		endcase
	endfunction

	// result side: random stalls plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_tog != hold_seen) begin
			hold_seen <= hold_tog;
			rx_hold_left <= RX_HOLD;
			res_ch.ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			res_ch.ready <= 1'b0;
		end else if (rx_stall_left > 0) begin
			rx_stall_left <= rx_stall_left - 1;
			res_ch.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 99) < 20) begin
			rx_stall_left <= pick_gap();
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (drive_q.size() == 0) begin
				$error("result word with nothing expected: drive %h boost %h pulling %h",
					res_ch.valve_drive, res_ch.boost_drive, res_ch.pulling_mask);
				err_cnt++;
			end else begin
				want = drive_q.pop_front();
				if (res_ch.valve_drive !== want.valve_drive) begin
					$error("valve_drive: expected %h, got %h",
						want.valve_drive, res_ch.valve_drive);
					err_cnt++;
				end
				if (res_ch.boost_drive !== want.boost_drive) begin
					$error("boost_drive: expected %h, got %h",
						want.boost_drive, res_ch.boost_drive);
					err_cnt++;
				end
				if (res_ch.pulling_mask !== want.pulling_mask) begin
					$error("pulling_mask: expected %h, got %h",
						want.pulling_mask, res_ch.pulling_mask);
					err_cnt++;
				end
				if (res_ch.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, res_ch.status);
					err_cnt++;
				end
				if (res_ch.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, res_ch.last);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL valve_pull_in_boost_sequencer_core");
			$finish;
		end
	end

	task automatic send_word(kind_t k, logic [TARGET_W-1:0] tgt, logic [NOW_W-1:0] now);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid  <= 1'b1;
		item_ch.kind   <= k;
		item_ch.target <= tgt;
		item_ch.now_ms <= now;
		do @(posedge clk); while (!item_ch.ready);
		predict_drive(k, tgt, now);
	endtask

	// sender pauses until every expected word is back
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (drive_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic cfg_write(logic [PIT_W-1:0] val);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.pull_in_time_ms <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		pull_in_ms = val;
		@(posedge clk);
	endtask

	task automatic test_directed();
		logic [NOW_W-1:0] t0;
		logic [NOW_W-1:0] t1;
		t0 = 32'hFFFF_FF00;
		send_word(KIND_SET, 16'h0000, t0);
		send_word(KIND_SET, 16'h01FF, t0);
		send_word(KIND_TICK, '0, t0 + 199);
		// elapsed time reaches the 200 ms pull-in time here, just short of the 32-bit wrap
		send_word(KIND_TICK, '0, t0 + 200);
		t1 = t0 + 202;
		send_word(KIND_SET, 16'h00F0, t0 + 201);
		send_word(KIND_SET, 16'h01F1, t1);
		// re-requesting open valves must not restart their pull-in
		send_word(KIND_SET, 16'h01F1, t1 + 150);
		send_word(KIND_TICK, '0, t1 + 199);
		send_word(KIND_TICK, '0, t1 + 200);
		send_word(KIND_SET, 16'h001B, t1 + 201);
		send_word(KIND_CANCEL, '0, t1 + 202);
		send_word(KIND_SET, 16'h0200, t1 + 203);
		send_word(KIND_SET, 16'hFE00, t1 + 204);
		send_word(KIND_SET, 16'hFFFF, t1 + 205);
		send_word(KIND_TICK, '0, t1 + 206);
		send_word(KIND_SET, 16'h0049, t1 + 207);
		send_word(KIND_TICK, '0, t1 + 207);
		send_word(KIND_CANCEL, '0, t1 + 208);
		send_word(KIND_SET, 16'h01FF, t1 + 209);
		send_word(KIND_TICK, '0, 32'h8000_0000);
		clock_ms = 32'h8000_0000;
	endtask

	task automatic test_config_extremes();
		cfg_write(16'd1);
		send_word(KIND_SET, 16'h0124, clock_ms);
		send_word(KIND_TICK, '0, clock_ms);
		send_word(KIND_TICK, '0, clock_ms + 1);
		cfg_write(16'hFFFF);
		send_word(KIND_SET, 16'h0092, clock_ms + 2);
		send_word(KIND_TICK, '0, clock_ms + 2 + 65534);
		send_word(KIND_TICK, '0, clock_ms + 2 + 65535);
		clock_ms = clock_ms + 2 + 65535;
		// zero pull-in time: every pull-in ends at the next tick
		cfg_write(16'd0);
		send_word(KIND_SET, 16'h0007, clock_ms);
		send_word(KIND_TICK, '0, clock_ms);
		cfg_write(16'd200);
	endtask

	task automatic random_word();
		int r;
		logic [TARGET_W-1:0] tgt;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			if ($urandom_range(0, 1)) begin
				tgt = TARGET_W'(coils_on ^ valve_mask_t'(1 << $urandom_range(0, VALVE_COUNT-1)));
			end else begin
				tgt = TARGET_W'($urandom_range(0, 511));
			end
			clock_ms = clock_ms + $urandom_range(0, 3);
			send_word(KIND_SET, tgt, clock_ms);
		end else if (r < 75) begin
			clock_ms = clock_ms + $urandom_range(0, int'(pull_in_ms) / 2 + 2);
			send_word(KIND_TICK, TARGET_W'($urandom_range(0, 65535)), clock_ms);
		end else if (r < 85) begin
			clock_ms = clock_ms + $urandom_range(0, 3);
			send_word(KIND_CANCEL, TARGET_W'($urandom_range(0, 65535)), clock_ms);
		end else if (r < 93) begin
			tgt = TARGET_W'($urandom_range(0, 65535)) | TARGET_W'(1 << $urandom_range(9, 15));
			send_word(KIND_SET, tgt, clock_ms);
		end else begin
			// timestamp jumps anywhere, forward or back
			clock_ms = $urandom();
			send_word(KIND_TICK, '0, clock_ms);
		end
	endtask

	task automatic test_random_traffic();
		logic [PIT_W-1:0] pit;
		for (int ph = 0; ph < 8; ph++) begin
			case ($urandom_range(0, 4))
				0: pit = 16'd1;
				1: pit = PIT_W'($urandom_range(2, 20));
				2: pit = PIT_W'($urandom_range(21, 1000));
				3: pit = PIT_W'($urandom_range(1001, 65534));
				default: pit = 16'hFFFF;
			endcase
			cfg_write(pit);
			no_idle = (ph == 3);
			repeat (48) random_word();
		end
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		drain();
		no_idle = 1'b1;
		hold_tog <= ~hold_tog;
		repeat (40) random_word();
		drain();
		no_idle = 1'b0;
	endtask

	task automatic test_fault_latch();
		send_word(KIND_SET, 16'h01FF, clock_ms);
		send_word(KIND_FAIL, 16'h0155, clock_ms + 1);
		send_word(KIND_SET, 16'h000F, clock_ms + 2);
		send_word(KIND_TICK, '0, clock_ms + 100000);
		send_word(KIND_CANCEL, '0, clock_ms + 100001);
		send_word(KIND_SET, 16'hFFFF, clock_ms + 100002);
		send_word(KIND_FAIL, 16'hFFFF, 32'hFFFF_FFFF);
	endtask

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_SET;
		item_ch.target = '0;
		item_ch.now_ms = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.pull_in_time_ms = '0;
		coils_on = '0;
		pulling = '0;
		boost_en = '0;
		fault = 1'b0;
		pull_in_ms = PIT_RESET;
		clock_ms = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_directed();
		test_config_extremes();
		test_random_traffic();
		test_backpressure();
		test_fault_latch();

		drain();
		repeat (20) @(posedge clk);
		if (err_cnt == 0) begin
			$display("PASS valve_pull_in_boost_sequencer_core");
		end else begin
			$display("FAIL valve_pull_in_boost_sequencer_core");
		end
		$finish;
	end

endmodule
